// File: hdl/clrs_pkg.sv
`default_nettype none

package clrs_pkg;

	// Generator geometry
	localparam int unsigned NUM_LFSR = 5;
	localparam int unsigned LFSR_W   = 32;
	localparam int unsigned OUT_W    = 32;
	localparam int unsigned CFG_IDX_W = 3;

	// Default statistics counter width
	localparam int unsigned COUNT_WIDTH_DEF = 32;

	// Seed value after reset
	localparam logic [LFSR_W-1:0] SEED_RESET = 32'd1;

	typedef logic [LFSR_W-1:0] lfsr_word_t;
	typedef logic [4:0]        tap_idx_t;

	// Three feedback taps per shift register
	localparam tap_idx_t TAP_TBL [NUM_LFSR][3] = '{
		'{5'd15, 5'd28, 5'd3},
		'{5'd30, 5'd16, 5'd5},
		'{5'd12, 5'd17, 5'd2},
		'{5'd31, 5'd23, 5'd8},
		'{5'd7,  5'd1,  5'd10}
	};

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SEED_A = 3'd0,
		CFG_SEED_B = 3'd1,
		CFG_SEED_C = 3'd2,
		CFG_SEED_D = 3'd3,
		CFG_SEED_E = 3'd4
	} cfg_reg_t;

	// Control from the top level to the shift register bank
	typedef struct packed {
		logic step;
		logic reload;
	} lfsr_ctl_t;

endpackage

`default_nettype wire

// File: hdl/clrs_cmd_if.sv
`default_nettype none

interface clrs_cmd_if;
	logic valid;
	logic ready;
	logic restart;
	logic finish;

	modport source (output valid, output restart, output finish, input ready);
	modport sink (input valid, input restart, input finish, output ready);
endinterface

`default_nettype wire

// File: hdl/clrs_res_if.sv
`default_nettype none

interface clrs_res_if;
	logic        valid;
	logic        ready;
	logic        out_bit;
	logic [31:0] ones_total;
	logic [31:0] zeros_total;
	logic [31:0] longest_ones;
	logic [31:0] longest_zeros;
	logic [31:0] runs_of_four;
	logic [31:0] runs_of_five;
	logic [31:0] runs_of_six;

	modport source (
		output valid, output out_bit, output ones_total, output zeros_total,
		output longest_ones, output longest_zeros, output runs_of_four,
		output runs_of_five, output runs_of_six, input ready
	);
	modport sink (
		input valid, input out_bit, input ones_total, input zeros_total,
		input longest_ones, input longest_zeros, input runs_of_four,
		input runs_of_five, input runs_of_six, output ready
	);
endinterface

`default_nettype wire

// File: hdl/clrs_lfsr_bank.sv
`default_nettype none

module clrs_lfsr_bank
	import clrs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire lfsr_ctl_t  ctl,
	input  wire lfsr_word_t seed [NUM_LFSR],
	output logic            gen_bit
);

	lfsr_word_t sr_q [NUM_LFSR];
	lfsr_word_t src  [NUM_LFSR];
	logic [NUM_LFSR-1:0] fb;

	// Pick current contents or fresh seeds, form feedback bits
	always_comb begin
		for (int i = 0; i < NUM_LFSR; i++) begin
			src[i] = ctl.reload ? seed[i] : sr_q[i];
			fb[i]  = src[i][TAP_TBL[i][0]] ^ src[i][TAP_TBL[i][1]] ^ src[i][TAP_TBL[i][2]];
		end
	end

	assign gen_bit = ^fb;

	// Shift left, taking in own feedback bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LFSR; i++) begin
				sr_q[i] <= SEED_RESET;
			end
		end else if (ctl.step) begin
			for (int i = 0; i < NUM_LFSR; i++) begin
				sr_q[i] <= {src[i][LFSR_W-2:0], fb[i]};
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/combined_lfsr_run_statistics_unit.sv
`default_nettype none

// Combined LFSR bit generator with run statistics. Each command item yields
// one result item: the XOR of five 32-bit shift registers' feedback bits plus
// saturating counts of ones, zeros, longest runs and completed runs of four,
// five and six equal bits. restart reloads the seeds (configuration indexes
// 0..4) and clears the statistics before the bit is generated; finish folds
// the open run into the longest-run figures only. One item is accepted per
// clock unless a stalled result blocks the command side. An item passes a
// command register and then a result register before its result item is
// offered. With the result side ready the block takes a new item every cycle;
// a stalled result holds one further item in the command register, and only
// then is the command side blocked. Written seeds take effect at the next
// restart; reset restores the reset seed.
module combined_lfsr_run_statistics_unit
	import clrs_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	clrs_cmd_if.sink                  cmd,
	clrs_res_if.source                res,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [LFSR_W-1:0]    cfg_data
);

	typedef logic [COUNT_WIDTH-1:0] cnt_t;

	function automatic cnt_t sat_inc(input cnt_t v);
		return (&v) ? v : v + COUNT_WIDTH'(1);
	endfunction

	function automatic logic [OUT_W-1:0] to_out(input cnt_t v);
		logic [COUNT_WIDTH+OUT_W-1:0] w;
		w = {{OUT_W{1'b0}}, v};
		return w[OUT_W-1:0];
	endfunction

	// Seed registers
	lfsr_word_t seed_q [NUM_LFSR];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LFSR; i++) begin
				seed_q[i] <= SEED_RESET;
			end
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_SEED_A: seed_q[0] <= cfg_data;
				CFG_SEED_B: seed_q[1] <= cfg_data;
				CFG_SEED_C: seed_q[2] <= cfg_data;
				CFG_SEED_D: seed_q[3] <= cfg_data;
				CFG_SEED_E: seed_q[4] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake and command register
	logic s1_valid_q;
	logic restart_s1;
	logic finish_s1;
	logic res_valid_q;
	logic adv;
	logic accept;

	assign adv       = s1_valid_q && (!res_valid_q || res.ready);
	assign cmd.ready = !s1_valid_q || adv;
	assign accept    = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (cmd.ready) begin
			s1_valid_q <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			restart_s1 <= cmd.restart;
			finish_s1  <= cmd.finish;
		end
	end

	// Shift register bank
	lfsr_ctl_t lfsr_ctl;
	logic      gen_bit;

	assign lfsr_ctl.step   = adv;
	assign lfsr_ctl.reload = restart_s1;

	clrs_lfsr_bank u_bank (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (lfsr_ctl),
		.seed    (seed_q),
		.gen_bit (gen_bit)
	);

	// Statistics state
	cnt_t ones_q, zeros_q, long1_q, long0_q, r4_q, r5_q, r6_q, run_q;
	logic prev_q, started_q;
	cnt_t ones_n, zeros_n, long1_n, long0_n, r4_n, r5_n, r6_n, run_n;
	logic prev_c, started_c;

	// Next statistics for the item in the command register
	always_comb begin
		ones_n    = restart_s1 ? '0 : ones_q;
		zeros_n   = restart_s1 ? '0 : zeros_q;
		long1_n   = restart_s1 ? '0 : long1_q;
		long0_n   = restart_s1 ? '0 : long0_q;
		r4_n      = restart_s1 ? '0 : r4_q;
		r5_n      = restart_s1 ? '0 : r5_q;
		r6_n      = restart_s1 ? '0 : r6_q;
		run_n     = restart_s1 ? COUNT_WIDTH'(1) : run_q;
		prev_c    = restart_s1 ? 1'b0 : prev_q;
		started_c = restart_s1 ? 1'b0 : started_q;

		if (gen_bit) begin
			ones_n = sat_inc(ones_n);
		end else begin
			zeros_n = sat_inc(zeros_n);
		end

		// Extend the run or close it out
		if (started_c) begin
			if (gen_bit == prev_c) begin
				run_n = sat_inc(run_n);
			end else begin
				if (prev_c) begin
					if (run_n > long1_n) long1_n = run_n;
				end else begin
					if (run_n > long0_n) long0_n = run_n;
				end
				if (run_n == COUNT_WIDTH'(4)) begin
					r4_n = sat_inc(r4_n);
				end else if (run_n == COUNT_WIDTH'(5)) begin
					r5_n = sat_inc(r5_n);
				end else if (run_n == COUNT_WIDTH'(6)) begin
					r6_n = sat_inc(r6_n);
				end
				run_n = COUNT_WIDTH'(1);
			end
		end

		// Fold the open run into the longest figure on finish
		if (finish_s1) begin
			if (gen_bit) begin
				if (run_n > long1_n) long1_n = run_n;
			end else begin
				if (run_n > long0_n) long0_n = run_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ones_q    <= '0;
			zeros_q   <= '0;
			long1_q   <= '0;
			long0_q   <= '0;
			r4_q      <= '0;
			r5_q      <= '0;
			r6_q      <= '0;
			run_q     <= COUNT_WIDTH'(1);
			prev_q    <= 1'b0;
			started_q <= 1'b0;
		end else if (adv) begin
			ones_q    <= ones_n;
			zeros_q   <= zeros_n;
			long1_q   <= long1_n;
			long0_q   <= long0_n;
			r4_q      <= r4_n;
			r5_q      <= r5_n;
			r6_q      <= r6_n;
			run_q     <= run_n;
			prev_q    <= gen_bit;
			started_q <= 1'b1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	logic              out_bit_q;
	logic [OUT_W-1:0]  ones_out_q, zeros_out_q, long1_out_q, long0_out_q;
	logic [OUT_W-1:0]  r4_out_q, r5_out_q, r6_out_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			out_bit_q   <= gen_bit;
			ones_out_q  <= to_out(ones_n);
			zeros_out_q <= to_out(zeros_n);
			long1_out_q <= to_out(long1_n);
			long0_out_q <= to_out(long0_n);
			r4_out_q    <= to_out(r4_n);
			r5_out_q    <= to_out(r5_n);
			r6_out_q    <= to_out(r6_n);
		end
	end

	assign res.valid         = res_valid_q;
	assign res.out_bit       = out_bit_q;
	assign res.ones_total    = ones_out_q;
	assign res.zeros_total   = zeros_out_q;
	assign res.longest_ones  = long1_out_q;
	assign res.longest_zeros = long0_out_q;
	assign res.runs_of_four  = r4_out_q;
	assign res.runs_of_five  = r5_out_q;
	assign res.runs_of_six   = r6_out_q;

endmodule

`default_nettype wire

// File: hdl/clrs_checker.sv
`default_nettype none

module clrs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cmd_valid,
	input wire logic        cmd_ready,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic        res_out_bit,
	input wire logic [31:0] res_ones_total,
	input wire logic [31:0] res_zeros_total
);

	// Stalled result stays offered
	a_res_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// Stalled result keeps its payload
	a_res_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_out_bit) && $stable(res_ones_total)
			&& $stable(res_zeros_total))
		else $error("result payload changed while stalled");

	// Draining a result always frees the command side
	a_drain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |-> cmd_ready)
		else $error("command side blocked while result drains");

	// Back pressure only when full and stalled downstream
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> res_valid && !res_ready)
		else $error("command side blocked without downstream stall");

endmodule

bind combined_lfsr_run_statistics_unit clrs_checker u_clrs_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cmd_valid       (cmd.valid),
	.cmd_ready       (cmd.ready),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.res_out_bit     (res.out_bit),
	.res_ones_total  (res.ones_total),
	.res_zeros_total (res.zeros_total)
);

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import clrs_pkg::*;

	localparam int unsigned CNT_W       = COUNT_WIDTH_DEF;
	localparam int unsigned CYCLE_LIMIT = 300000;

	// Feedback taps of each shift register
	localparam int unsigned FB_TAPS [NUM_LFSR][3] = '{
		'{15, 28, 3},
		'{30, 16, 5},
		'{12, 17, 2},
		'{31, 23, 8},
		'{7, 1, 10}
	};

	// Saturation value of every statistics counter
	localparam logic [63:0] CNT_MAX = (64'd1 << CNT_W) - 64'd1;

	typedef enum int unsigned {
		ST_ONES, ST_ZEROS, ST_LONG1, ST_LONG0, ST_RUN4, ST_RUN5, ST_RUN6, ST_COUNT
	} stat_idx_t;

	typedef struct packed {
		logic        out_bit;
		logic [31:0] ones_total;
		logic [31:0] zeros_total;
		logic [31:0] longest_ones;
		logic [31:0] longest_zeros;
		logic [31:0] runs_of_four;
		logic [31:0] runs_of_five;
		logic [31:0] runs_of_six;
	} bit_stats_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [LFSR_W-1:0] cfg_data;

	clrs_cmd_if cmd_ch ();
	clrs_res_if res_ch ();

	combined_lfsr_run_statistics_unit #(
		.COUNT_WIDTH(CNT_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	// Generator copy: seeds, shift registers and run statistics
	lfsr_word_t seed_val [NUM_LFSR];
	lfsr_word_t lfsr_q [NUM_LFSR];
	logic last_bit;
	logic have_bit;
	logic [63:0] run_len;
	logic [63:0] tally [ST_COUNT];

	bit_stats_t stats_due_q[$];
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	bit no_idle = 1'b0;
	int unsigned sink_hold_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [63:0] sat_up(logic [63:0] v);
		return (v >= CNT_MAX) ? CNT_MAX : v + 64'd1;
	endfunction

	// Reload shift registers from the seeds and clear all statistics
	function automatic void reload_generator();
		for (int i = 0; i < NUM_LFSR; i++)
			lfsr_q[i] = seed_val[i];
		for (int k = 0; k < ST_COUNT; k++)
			tally[k] = 64'd0;
		last_bit = 1'b0;
		have_bit = 1'b0;
		run_len = 64'd1;
	endfunction

	function automatic void raise_longest(logic b, logic [63:0] len);
		if (b) begin
			if (len > tally[ST_LONG1])
				tally[ST_LONG1] = len;
		end else begin
			if (len > tally[ST_LONG0])
				tally[ST_LONG0] = len;
		end
	endfunction

	// Generate one bit and update the run statistics
	function automatic bit_stats_t next_bit_stats(logic restart, logic finish);
		logic [NUM_LFSR-1:0] fb;
		logic b;
		bit_stats_t r;
		if (restart)
			reload_generator();
		b = 1'b0;
		for (int i = 0; i < NUM_LFSR; i++) begin
			fb[i] = lfsr_q[i][FB_TAPS[i][0]] ^ lfsr_q[i][FB_TAPS[i][1]] ^
				lfsr_q[i][FB_TAPS[i][2]];
			b ^= fb[i];
		end
		if (b)
			tally[ST_ONES] = sat_up(tally[ST_ONES]);
		else
			tally[ST_ZEROS] = sat_up(tally[ST_ZEROS]);
		// close the run on a change of value
		if (have_bit) begin
			if (b == last_bit) begin
				run_len = sat_up(run_len);
			end else begin
				raise_longest(last_bit, run_len);
				case (run_len)
					64'd4: tally[ST_RUN4] = sat_up(tally[ST_RUN4]);
					64'd5: tally[ST_RUN5] = sat_up(tally[ST_RUN5]);
					64'd6: tally[ST_RUN6] = sat_up(tally[ST_RUN6]);
					default: ;
				endcase
				run_len = 64'd1;
			end
		end
		for (int i = 0; i < NUM_LFSR; i++)
			lfsr_q[i] = {lfsr_q[i][LFSR_W-2:0], fb[i]};
		have_bit = 1'b1;
		last_bit = b;
		// finish only folds the open run into the longest figure
		if (finish)
			raise_longest(b, run_len);
		r.out_bit       = b;
		r.ones_total    = tally[ST_ONES][31:0];
		r.zeros_total   = tally[ST_ZEROS][31:0];
		r.longest_ones  = tally[ST_LONG1][31:0];
		r.longest_zeros = tally[ST_LONG0][31:0];
		r.runs_of_four  = tally[ST_RUN4][31:0];
		r.runs_of_five  = tally[ST_RUN5][31:0];
		r.runs_of_six   = tally[ST_RUN6][31:0];
		return r;
	endfunction

	function automatic int unsigned draw_wait();
		return no_idle ? 0 : $urandom_range(0, 13);
	endfunction

	function automatic lfsr_word_t pick_seed();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return 32'd1;
			3: return 32'h8000_0000;
			default: return $urandom();
		endcase
	endfunction

	// Offer one item after a random gap and wait for it to be taken
	task automatic send_item(logic restart, logic finish);
		int unsigned gap;
		gap = draw_wait();
		@(negedge clk);
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			cmd_ch.restart <= 1'($urandom_range(0, 1));
			cmd_ch.finish <= 1'($urandom_range(0, 1));
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.restart <= restart;
		cmd_ch.finish <= finish;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		stats_due_q = {stats_due_q, next_bit_stats(restart, finish)};
	endtask

	// Drop valid and wait until every result is back
	task automatic settle();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (stats_due_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_seed(cfg_reg_t idx, lfsr_word_t value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		seed_val[idx] = value;
	endtask

	task automatic program_seeds(lfsr_word_t a, lfsr_word_t b, lfsr_word_t c,
			lfsr_word_t d, lfsr_word_t e);
		write_seed(CFG_SEED_A, a);
		write_seed(CFG_SEED_B, b);
		write_seed(CFG_SEED_C, c);
		write_seed(CFG_SEED_D, d);
		write_seed(CFG_SEED_E, e);
	endtask

	// Reset seeds, all-ones, all-zero and mixed seeds, restart in mid-sequence
	task automatic test_directed();
		repeat (4) send_item(1'b0, 1'b0);
		send_item(1'b0, 1'b1);
		send_item(1'b0, 1'b0);
		settle();
		program_seeds('1, '1, '1, '1, '1);
		// new seeds stay unused until the restart
		send_item(1'b0, 1'b0);
		send_item(1'b1, 1'b0);
		repeat (4) send_item(1'b0, 1'b0);
		send_item(1'b0, 1'b1);
		settle();
		program_seeds('0, '0, '0, '0, '0);
		send_item(1'b1, 1'b0);
		repeat (3) send_item(1'b0, 1'b0);
		send_item(1'b0, 1'b1);
		settle();
		program_seeds(32'h8000_0000, '1, '0, 32'd1, 32'h5555_5555);
		send_item(1'b1, 1'b1);
		repeat (3) send_item(1'b0, 1'b0);
		send_item(1'b1, 1'b0);
		settle();
	endtask

	// Long sequences from fresh seeds, with rare restarts and finishes
	task automatic test_random_stream(int unsigned n_items, bit quiet);
		program_seeds(pick_seed(), pick_seed(), pick_seed(), pick_seed(), pick_seed());
		no_idle = quiet;
		send_item(1'($urandom_range(0, 1)), 1'b0);
		repeat (n_items - 1)
			send_item($urandom_range(0, 63) == 0, $urandom_range(0, 9) == 0);
		no_idle = 1'b0;
		settle();
	endtask

	// Hold the result side off while items keep coming back to back
	task automatic test_backpressure();
		no_idle = 1'b1;
		sink_hold_cycles = 60;
		send_item(1'b1, 1'b0);
		repeat (29)
			send_item(1'b0, $urandom_range(0, 7) == 0);
		no_idle = 1'b0;
		settle();
	endtask

	// Result side: random stalls, or a long hold when one is requested
	initial begin : result_sink
		int unsigned w;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sink_hold_cycles != 0) begin
				res_ch.ready <= 1'b0;
				repeat (sink_hold_cycles) @(negedge clk);
				sink_hold_cycles = 0;
			end else begin
				w = draw_wait();
				if (w != 0) begin
					res_ch.ready <= 1'b0;
					repeat (w) @(negedge clk);
				end
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid)
				@(posedge clk);
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Compare each result with the oldest expectation
	always @(posedge clk) begin : result_check
		bit_stats_t want;
		if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (stats_due_q.size() == 0) begin
				$error("result item with no expectation pending");
				fail_count++;
			end else begin
				want = stats_due_q.pop_front();
				check_field("out_bit", 32'(want.out_bit), 32'(res_ch.out_bit));
				check_field("ones_total", want.ones_total, res_ch.ones_total);
				check_field("zeros_total", want.zeros_total, res_ch.zeros_total);
				check_field("longest_ones", want.longest_ones, res_ch.longest_ones);
				check_field("longest_zeros", want.longest_zeros, res_ch.longest_zeros);
				check_field("runs_of_four", want.runs_of_four, res_ch.runs_of_four);
				check_field("runs_of_five", want.runs_of_five, res_ch.runs_of_five);
				check_field("runs_of_six", want.runs_of_six, res_ch.runs_of_six);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("combined_lfsr_run_statistics_unit regression: fail");
			$finish;
		end
	end

	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.restart = 1'b0;
		cmd_ch.finish = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		for (int i = 0; i < NUM_LFSR; i++)
			seed_val[i] = SEED_RESET;
		reload_generator();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_stream(160, 1'b0);
		test_random_stream(160, 1'b1);
		test_random_stream(160, 1'b0);
		test_backpressure();
		test_random_stream(160, 1'b0);
		test_random_stream(160, 1'b1);
		test_random_stream(160, 1'b0);

		repeat (8) @(posedge clk);
		if (fail_count == 0 && stats_due_q.size() == 0)
			$display("combined_lfsr_run_statistics_unit regression: pass");
		else
			$display("combined_lfsr_run_statistics_unit regression: fail");
		$finish;
	end

endmodule
